// ----- design/mvf_pkg.sv -----
// Shared types and constants for the missing value finder.
`timescale 1ns / 1ps

package mvf_pkg;

    localparam int VALUE_W       = 6;
    localparam int BITMAP_DEPTH  = 1 << VALUE_W;
    localparam int DEF_MAX_COUNT = 63;

    typedef logic [VALUE_W-1:0] value_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_LOAD,
        ST_SCAN,
        ST_DRAIN,
        ST_FINAL
    } mvf_state_t;

    // One port of the bitmap RAM: write and read share the address.
    typedef struct packed {
        logic   wr_en;
        logic   wr_bit;
        logic   rd_en;
        value_t addr;
    } ram_req_t;

endpackage

// ----- design/mvf_bitmap_ram.sv -----
// Presence bitmap RAM: one bit per value, registered read, read-before-write.
`timescale 1ns / 1ps

module mvf_bitmap_ram
    import mvf_pkg::*;
(
    input  logic     aclk,
    input  ram_req_t req,
    output logic     rd_bit
);

    logic mem [BITMAP_DEPTH];
    logic rd_bit_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.addr] <= req.wr_bit;
        end
        if (req.rd_en) begin
            rd_bit_reg <= mem[req.addr];
        end
    end

    assign rd_bit = rd_bit_reg;

endmodule

// ----- design/missing_value_finder_top.sv -----
// Missing value finder: loads a set into a presence bitmap RAM, then scans it.
// Loading takes one transaction per cycle. The set's last item starts a scan of all 64
// entries (read and clear one per cycle while the output does not stall); input is held off
// through the scan, a drain state and a final state, and longer with any output stall.
// Each missing value waits one-deep until the next is found or the scan ends, then leaves.
// Reset (aresetn low, synchronous) runs a clearing pass over all 64 RAM entries first.
`timescale 1ns / 1ps

module missing_value_finder_top
    import mvf_pkg::*;
#(
    parameter int MAX_COUNT = DEF_MAX_COUNT
) (
    input  logic       aclk,
    input  logic       aresetn,
    // input items
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [5:0] value, [7:6] zero
    input  logic       s_axis_tlast,   // last_item
    // results
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [5:0] missing_value, [7:6] zero
    output logic       m_axis_tlast,   // last_missing
    output logic       m_axis_tuser    // [0] overflow
);

    // Item count saturates at MAX_COUNT, and never above the 6-bit limit of 63.
    localparam int     CAP_INT   = (MAX_COUNT < BITMAP_DEPTH - 1) ? MAX_COUNT
                                                                   : BITMAP_DEPTH - 1;
    localparam value_t COUNT_CAP = VALUE_W'(CAP_INT);
    localparam value_t ADDR_LAST = VALUE_W'(BITMAP_DEPTH - 1);

    mvf_state_t state_reg, state_next;

    value_t addr_reg;        // clearing pass / scan read pointer
    value_t count_reg;       // items counted in the current set (n)
    logic   overflow_reg;    // a transaction of this set was dropped

    // read stage: index of the bit that the RAM returns this cycle
    logic   rd_valid_reg;
    value_t rd_idx_reg;

    // one-deep lookahead so the highest missing value can be flagged last
    logic   pend_valid_reg;
    value_t pend_value_reg;

    // output register
    logic   m_valid_reg;
    value_t m_value_reg;
    logic   m_last_reg;
    logic   m_ovf_reg;

    ram_req_t ram_req;
    logic     rd_bit;

    logic   in_accept;
    logic   counted;
    logic   adv;
    logic   issue;
    logic   process_bit;
    logic   hit;
    logic   push_mid;
    logic   push_final;
    value_t in_value;

    assign in_value  = s_axis_tdata[VALUE_W-1:0];
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign counted   = count_reg < COUNT_CAP;

    // Scan advances only when the output register can take a result.
    assign adv         = !m_valid_reg || m_axis_tready;
    assign process_bit = rd_valid_reg && adv;
    assign hit         = process_bit && !rd_bit && (rd_idx_reg <= count_reg);
    assign push_mid    = hit && pend_valid_reg;

    always_comb begin
        state_next    = state_reg;
        issue         = 1'b0;
        push_final    = 1'b0;
        s_axis_tready = 1'b0;
        ram_req       = '{wr_en: 1'b0, wr_bit: 1'b0, rd_en: 1'b0, addr: addr_reg};

        case (state_reg)
            ST_CLEAR: begin
                ram_req.wr_en = 1'b1;
                if (addr_reg == ADDR_LAST) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                s_axis_tready = 1'b1;
                ram_req.addr  = in_value;
                ram_req.wr_bit = 1'b1;
                ram_req.wr_en = in_accept && counted;
                if (in_accept && s_axis_tlast) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // read each entry and clear it behind the read
                issue         = adv;
                ram_req.rd_en = adv;
                ram_req.wr_en = adv;
                if (adv && addr_reg == ADDR_LAST) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (adv) begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                if (adv) begin
                    push_final = pend_valid_reg;
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            addr_reg       <= '0;
            count_reg      <= '0;
            overflow_reg   <= 1'b0;
            rd_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (state_reg == ST_CLEAR || issue) begin
                addr_reg <= addr_reg + 1'b1;
            end

            if (in_accept) begin
                if (counted) begin
                    count_reg <= count_reg + 1'b1;
                end else begin
                    overflow_reg <= 1'b1;
                end
            end else if (state_reg == ST_FINAL && adv) begin
                count_reg    <= '0;
                overflow_reg <= 1'b0;
            end

            if (adv) begin
                rd_valid_reg <= issue;
            end

            if (hit) begin
                pend_valid_reg <= 1'b1;
            end else if (push_final) begin
                pend_valid_reg <= 1'b0;
            end

            if (push_mid || push_final) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (issue) begin
            rd_idx_reg <= addr_reg;
        end
        if (hit) begin
            pend_value_reg <= rd_idx_reg;
        end
        if (push_mid || push_final) begin
            m_value_reg <= pend_value_reg;
            m_last_reg  <= push_final;
            m_ovf_reg   <= overflow_reg;
        end
    end

    mvf_bitmap_ram u_bitmap (
        .aclk   (aclk),
        .req    (ram_req),
        .rd_bit (rd_bit)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(8 - VALUE_W){1'b0}}, m_value_reg};
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tuser  = m_ovf_reg;

endmodule

// ----- test/mvf_result_checker.sv -----
// Result checker for the missing value finder: predicts missing values and compares them.
`timescale 1ns / 1ps

module mvf_result_checker
    import mvf_pkg::*;
#(
    parameter int MAX_COUNT = DEF_MAX_COUNT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [5:0] value, [7:6] zero
    input  logic       s_axis_tlast,   // last_item
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,   // [5:0] missing_value, [7:6] zero
    input  logic       m_axis_tlast,   // last_missing
    input  logic       m_axis_tuser,   // [0] overflow
    output int         error_count,
    output int         pending,
    output int         values_checked,
    output int         sets_closed,
    output int         overflow_sets
);

    // item counter is VALUE_W bits wide, so the cap cannot go past its top value
    localparam int COUNT_CAP = (MAX_COUNT < BITMAP_DEPTH - 1) ? MAX_COUNT : BITMAP_DEPTH - 1;

    typedef struct packed {
        value_t value;
        logic   last;
        logic   overflow;
    } missing_t;

    missing_t                expected_missing[$];
    logic [BITMAP_DEPTH-1:0] present_bits;
    int                      held_count;
    logic                    dropped_any;

    initial begin
        error_count    = 0;
        values_checked = 0;
        sets_closed    = 0;
        overflow_sets  = 0;
        pending        = 0;
    end

    // Scan 0..n in ascending order, queue every absent value, then start a fresh set.
    task automatic close_set();
        int       top_gap;
        missing_t rec;
        top_gap = 0;
        for (int i = 0; i <= held_count; i++) begin
            if (!present_bits[i]) top_gap = i;
        end
        for (int i = 0; i <= held_count; i++) begin
            if (!present_bits[i]) begin
                rec.value    = value_t'(i);
                rec.last     = (i == top_gap);
                rec.overflow = dropped_any;
                expected_missing.push_back(rec);
            end
        end
        sets_closed++;
        if (dropped_any) overflow_sets++;
        present_bits = '0;
        held_count   = 0;
        dropped_any  = 1'b0;
    endtask

    always @(posedge aclk) begin
        missing_t want;
        if (!aresetn) begin
            present_bits = '0;
            held_count   = 0;
            dropped_any  = 1'b0;
            expected_missing.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_missing.size() == 0) begin
                    error_count++;
                    $error("unexpected result: missing_value=%0d last_missing=%0b overflow=%0b",
                           m_axis_tdata[VALUE_W-1:0], m_axis_tlast, m_axis_tuser);
                end else begin
                    want = expected_missing.pop_front();
                    values_checked++;
                    if (m_axis_tdata[VALUE_W-1:0] !== want.value) begin
                        error_count++;
                        $error("missing_value: expected %0d, got %0d",
                               want.value, m_axis_tdata[VALUE_W-1:0]);
                    end
                    if (m_axis_tlast !== want.last) begin
                        error_count++;
                        $error("last_missing: expected %0b, got %0b", want.last, m_axis_tlast);
                    end
                    if (m_axis_tuser !== want.overflow) begin
                        error_count++;
                        $error("overflow: expected %0b, got %0b", want.overflow, m_axis_tuser);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (held_count < COUNT_CAP) begin
                    present_bits[s_axis_tdata[VALUE_W-1:0]] = 1'b1;
                    held_count++;
                end else begin
                    dropped_any = 1'b1;
                end
                if (s_axis_tlast) close_set();
            end
        end
        pending <= expected_missing.size();
    end

endmodule

// ----- test/testbench.sv -----
// Testbench top for the missing value finder: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module testbench;
    import mvf_pkg::*;

    localparam int ITEM_TARGET    = 370;   // random part stops once this many items went in
    localparam int RX_HOLD_CYCLES = 300;   // long receiver hold-off, fills the block up
    localparam int DRAIN_CYCLES   = 100;
    localparam int IDLE_PCT       = 34;

    // kinds of sets the random part builds
    typedef enum int {
        SET_CLEAN,      // 0..n with exactly one value left out, shuffled
        SET_NOISY,      // random values, duplicates and values above n
        SET_REPEATS,    // values inside 0..n with many duplicates
        SET_FULL,       // 63 distinct values, largest scan without overflow
        SET_OVERFLOW    // more items than the cap; every item past the cap gets dropped
    } set_kind_t;

    logic       aclk;
    logic       aresetn;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;    // [5:0] value, [7:6] zero
    logic       s_axis_tlast;    // last_item
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;    // [5:0] missing_value, [7:6] zero
    logic       m_axis_tlast;    // last_missing
    logic       m_axis_tuser;    // [0] overflow

    int error_count;
    int pending;
    int values_checked;
    int sets_closed;
    int overflow_sets;

    // shared between the sender and the receiver processes
    bit steady;      // no idling on either side while set
    bit hold_go;     // asks the receiver for its one long hold-off

    int     items_sent;
    int     sets_sent;
    value_t set_values[$];

    missing_value_finder_top i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    mvf_result_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tlast   (s_axis_tlast),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tlast   (m_axis_tlast),
        .m_axis_tuser   (m_axis_tuser),
        .error_count    (error_count),
        .pending        (pending),
        .values_checked (values_checked),
        .sets_closed    (sets_closed),
        .overflow_sets  (overflow_sets)
    );

    // 4 ns period
    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // Offer one item and hold it until the block takes it. Random idle cycles
    // go in front of the item unless a steady stretch is running. Called and
    // returns on a rising edge; tvalid stays high between back-to-back items.
    task automatic send_item(input value_t v, input logic last);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(8 - VALUE_W){1'b0}}, v};
        s_axis_tlast  <= last;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        items_sent++;
    endtask

    // Send the current set; the final element carries tlast.
    task automatic send_set();
        foreach (set_values[i]) send_item(set_values[i], i == set_values.size() - 1);
        sets_sent++;
    endtask

    // Fill set_values with a set of the given kind.
    task automatic build_set(input set_kind_t kind);
        int     n;
        int     extra;
        int     j;
        value_t tmp;
        set_values.delete();
        case (kind)
            SET_CLEAN, SET_FULL: begin
                if (kind == SET_FULL) begin
                    n = BITMAP_DEPTH - 1;
                end else if ($urandom_range(9) == 0) begin
                    n = $urandom_range(40, 13);
                end else begin
                    n = $urandom_range(12, 1);
                end
                for (int i = 0; i <= n; i++) set_values.push_back(value_t'(i));
                set_values.delete($urandom_range(n, 0));
                // Fisher-Yates shuffle
                for (int i = set_values.size() - 1; i > 0; i--) begin
                    j             = $urandom_range(i, 0);
                    tmp           = set_values[i];
                    set_values[i] = set_values[j];
                    set_values[j] = tmp;
                end
            end
            SET_NOISY: begin
                n = $urandom_range(20, 1);
                for (int i = 0; i < n; i++) set_values.push_back(value_t'($urandom_range(63, 0)));
            end
            SET_REPEATS: begin
                n = $urandom_range(15, 2);
                for (int i = 0; i < n; i++) set_values.push_back(value_t'($urandom_range(n, 0)));
            end
            SET_OVERFLOW: begin
                // all 64 values, then up to 5 more; only the first 63 get counted
                extra = $urandom_range(5, 0);
                for (int i = 0; i < BITMAP_DEPTH; i++) set_values.push_back(value_t'(i));
                for (int i = 0; i < extra; i++) begin
                    set_values.push_back(value_t'($urandom_range(63, 0)));
                end
                for (int i = set_values.size() - 1; i > 0; i--) begin
                    j             = $urandom_range(i, 0);
                    tmp           = set_values[i];
                    set_values[i] = set_values[j];
                    set_values[j] = tmp;
                end
            end
            default: set_values.push_back('0);
        endcase
    endtask

    // Receiver: random back-pressure, one long hold-off on request, none in steady stretches.
    initial begin
        bit held;
        held = 1'b0;
        m_axis_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_go && !held) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                // sender keeps offering items meanwhile; the block must stall its input
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
            end
            m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
            @(posedge aclk);
        end
    end

    // Stimulus and verdict.
    initial begin
        set_kind_t kind;
        int        set_idx;
        int        r;

        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        steady         = 1'b0;
        hold_go        = 1'b0;
        items_sent     = 0;
        sets_sent      = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- directed sets ---
        set_values = '{6'd0};                        // single item, missing 1
        send_set();
        set_values = '{6'd63};                       // top value above n: missing 0 and 1
        send_set();
        set_values = '{6'd1};                        // missing 0 only
        send_set();
        set_values = '{6'd0, 6'd1, 6'd2};            // gap only at n itself
        send_set();
        set_values = '{6'd3, 6'd3, 6'd3};            // duplicates widen the gap list
        send_set();
        set_values = '{6'd2, 6'd0, 6'd40};           // value above n is ignored
        send_set();
        set_values = '{6'd1, 6'd2, 6'd3, 6'd4, 6'd0}; // unordered, gap at n
        send_set();
        set_values = '{6'd42, 6'd21, 6'd63};         // alternating bit patterns and all ones, all out of range
        send_set();

        // --- random sets ---
        set_idx = 0;
        while (items_sent < ITEM_TARGET) begin
            r = $urandom_range(99);
            if (set_idx == 2) begin
                kind = SET_FULL;
            end else if (set_idx == 8) begin
                kind = SET_OVERFLOW;
            end else if (r < 65) begin
                kind = SET_CLEAN;
            end else if (r < 85) begin
                kind = SET_NOISY;
            end else begin
                kind = SET_REPEATS;
            end
            if (set_idx == 5) hold_go = 1'b1;
            steady = (set_idx >= 12 && set_idx < 18);
            build_set(kind);
            send_set();
            set_idx++;
        end
        s_axis_tvalid <= 1'b0;
        steady = 1'b0;

        // let the checker see the final transaction, then wait for every expected value
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d sets (%0d items), %0d of them overflowing, with one long",
                 sets_sent, items_sent, overflow_sets);
        $display("receiver hold-off; %0d missing values checked over %0d closed sets.",
                 values_checked, sets_closed);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Hang guard: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
